// ===== hw/rtl/fbpa_pkg.sv =====
package fbpa_pkg;

   // Pool geometry.
   localparam int POOL_BLOCKS = 1024;
   localparam int IDX_W = $clog2(POOL_BLOCKS);
   localparam int LINK_W = IDX_W + 1;
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_BLOCKS);

   // Register widths.
   localparam int COUNT_W = 11;
   localparam int SIZE_W = 16;
   localparam int ALIGN_W = 13;
   localparam int ADDR_W = 48;
   localparam int CSR_IDX_W = 2;

   // Block stride and address product widths.
   localparam int STRIDE_W = SIZE_W + 1;
   localparam int PROD_W = IDX_W + STRIDE_W;

   // Width wide enough to compare the programmed count with the pool size.
   localparam int CMP_W = (LINK_W > COUNT_W) ? LINK_W : COUNT_W;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_COUNT     = 2'd0,
      CSR_BLOCK_SIZE      = 2'd1,
      CSR_BLOCK_ALIGNMENT = 2'd2,
      CSR_BASE_ADDRESS    = 2'd3
   } csr_index_type;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_ALLOC    = 2'd0,
      KIND_FREE     = 2'd1,
      KIND_FREE_ALL = 2'd2,
      KIND_NONE     = 2'd3
   } kind_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_RANGE     = 2'd2,
      STATUS_NULL_FREE = 2'd3
   } status_type;

   // Address geometry handed to the address unit.
   typedef struct packed {
      logic [SIZE_W-1:0]  block_size;
      logic [ALIGN_W-1:0] block_alignment;
      logic [ADDR_W-1:0]  base_address;
   } geom_type;

endpackage

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
// Fixed-size block pool allocator kept as a free list of block indices in a link RAM.
// Requests arrive on the req_ channel; each one gives exactly one beat on the rsp_ channel.
// A beat moves when valid is high and stall is low at a rising clock edge.
// Allocate pops the list head and returns its index and byte address, free pushes
// a block, free-all rebuilds the chain 0..count-1 in the link RAM.
// Steps per request: free, null free, out-of-range free, a none request and allocate
// on an empty list load the response register straight away; a successful allocate reads
// the head's link from the link RAM while the address unit multiplies the index by the
// stride, then adds the base; free-all writes the link RAM once per block in a sweep.
// The next request is taken only after the response register is loaded.
// The block takes one request at a time; req_stall is high while a request is in work.
// A finished response waits in the output register while the next request is taken,
// so a stalled receiver holds the following request only at its final step.
// Reset empties the free list, clears the in-use count and loads the register defaults
// (1024 blocks of 64 bytes, no alignment, base 0); call free-all before allocating.
// The user must write csr_ registers only while no request is in work; not enforced.
module fixed_block_pool_allocator (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_write,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]   csr_wdata,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [fbpa_pkg::IDX_W-1:0]    req_block_index,
   input  logic                          req_no_block,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [fbpa_pkg::IDX_W-1:0]    rsp_granted_index,
   output logic [fbpa_pkg::ADDR_W-1:0]   rsp_granted_address,
   output logic [fbpa_pkg::LINK_W-1:0]   rsp_used_blocks
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_LINK,
      ST_ALLOC_ADDR,
      ST_FILL,
      ST_EMIT
   } state_type;

   // Configuration registers.
   logic [fbpa_pkg::COUNT_W-1:0] block_count_ff;
   fbpa_pkg::geom_type           geom_ff;

   // Control state.
   state_type                    state_ff, state_in;
   logic [fbpa_pkg::LINK_W-1:0]  head_ff, head_in;
   logic [fbpa_pkg::LINK_W-1:0]  used_ff, used_in;
   logic [fbpa_pkg::IDX_W-1:0]   sweep_ff, sweep_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Pending result and output payload.
   logic [1:0]                   res_status_ff, res_status_in;
   logic [fbpa_pkg::IDX_W-1:0]   res_index_ff, res_index_in;
   logic [fbpa_pkg::ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic [fbpa_pkg::IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [fbpa_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [fbpa_pkg::LINK_W-1:0]  rsp_used_ff, rsp_used_in;

   // Link RAM and address unit connections.
   logic                         ram_wr_en;
   logic [fbpa_pkg::IDX_W-1:0]   ram_wr_addr;
   logic [fbpa_pkg::LINK_W-1:0]  ram_wr_data;
   logic [fbpa_pkg::IDX_W-1:0]   ram_rd_addr;
   logic [fbpa_pkg::LINK_W-1:0]  ram_rd_data;
   logic                         addr_start;
   logic                         addr_done;
   logic [fbpa_pkg::ADDR_W-1:0]  addr_value;

   logic [fbpa_pkg::CMP_W-1:0]   count_ext;
   logic [fbpa_pkg::LINK_W-1:0]  eff_count;
   logic [fbpa_pkg::LINK_W-1:0]  sweep_next;
   logic                         sweep_last;
   logic                         out_free;

   fbpa_link_ram #(
      .DEPTH(fbpa_pkg::POOL_BLOCKS),
      .WIDTH(fbpa_pkg::LINK_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fbpa_addr_unit u_addr_unit (
      .clock   (clock),
      .reset   (reset),
      .start   (addr_start),
      .index   (res_index_in),
      .geom    (geom_ff),
      .done    (addr_done),
      .address (addr_value)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff          <= fbpa_pkg::COUNT_W'(1024);
         geom_ff.block_size      <= fbpa_pkg::SIZE_W'(64);
         geom_ff.block_alignment <= '0;
         geom_ff.base_address    <= '0;
      end else if (csr_write) begin
         unique case (fbpa_pkg::csr_index_type'(csr_index))
            fbpa_pkg::CSR_BLOCK_COUNT: begin
               block_count_ff <= csr_wdata[fbpa_pkg::COUNT_W-1:0];
            end
            fbpa_pkg::CSR_BLOCK_SIZE: begin
               geom_ff.block_size <= csr_wdata[fbpa_pkg::SIZE_W-1:0];
            end
            fbpa_pkg::CSR_BLOCK_ALIGNMENT: begin
               geom_ff.block_alignment <= csr_wdata[fbpa_pkg::ALIGN_W-1:0];
            end
            fbpa_pkg::CSR_BASE_ADDRESS: begin
               geom_ff.base_address <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Effective block count is the programmed count limited to the pool size.
   always_comb begin
      count_ext = fbpa_pkg::CMP_W'(block_count_ff);
      if (count_ext > fbpa_pkg::CMP_W'(fbpa_pkg::POOL_BLOCKS)) begin
         eff_count = fbpa_pkg::LINK_NULL;
      end else begin
         eff_count = fbpa_pkg::LINK_W'(count_ext);
      end
      sweep_next = fbpa_pkg::LINK_W'(sweep_ff) + fbpa_pkg::LINK_W'(1);
      sweep_last = (sweep_next >= eff_count);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Request sequencer.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      used_in       = used_ff;
      sweep_in      = sweep_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_addr_in   = res_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = sweep_ff;
      ram_wr_data   = fbpa_pkg::LINK_NULL;
      ram_rd_addr   = head_ff[fbpa_pkg::IDX_W-1:0];
      addr_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_status_in = fbpa_pkg::STATUS_OK;
               res_index_in  = '0;
               res_addr_in   = '0;
               state_in      = ST_EMIT;
               unique case (fbpa_pkg::kind_type'(req_kind))
                  fbpa_pkg::KIND_ALLOC: begin
                     if (head_ff >= fbpa_pkg::LINK_NULL) begin
                        res_status_in = fbpa_pkg::STATUS_EMPTY;
                     end else begin
                        // Read the head's link and start the address multiply.
                        res_index_in = head_ff[fbpa_pkg::IDX_W-1:0];
                        addr_start   = 1'b1;
                        state_in     = ST_ALLOC_LINK;
                     end
                  end
                  fbpa_pkg::KIND_FREE: begin
                     if (req_no_block) begin
                        res_status_in = fbpa_pkg::STATUS_NULL_FREE;
                     end else if (fbpa_pkg::LINK_W'(req_block_index) >= eff_count) begin
                        res_status_in = fbpa_pkg::STATUS_RANGE;
                     end else begin
                        // Push the block: its link takes the old head.
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = req_block_index;
                        ram_wr_data = head_ff;
                        head_in     = fbpa_pkg::LINK_W'(req_block_index);
                        if (used_ff != '0) begin
                           used_in = used_ff - fbpa_pkg::LINK_W'(1);
                        end
                     end
                  end
                  fbpa_pkg::KIND_FREE_ALL: begin
                     used_in  = '0;
                     head_in  = fbpa_pkg::LINK_NULL;
                     sweep_in = '0;
                     if (eff_count != '0) begin
                        state_in = ST_FILL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ALLOC_LINK: begin
            // The popped block's link becomes the new head.
            if (ram_rd_data > fbpa_pkg::LINK_NULL) begin
               head_in = fbpa_pkg::LINK_NULL;
            end else begin
               head_in = ram_rd_data;
            end
            if (used_ff < fbpa_pkg::LINK_NULL) begin
               used_in = used_ff + fbpa_pkg::LINK_W'(1);
            end
            state_in = ST_ALLOC_ADDR;
         end
         ST_ALLOC_ADDR: begin
            if (addr_done) begin
               res_addr_in = addr_value;
               state_in    = ST_EMIT;
            end
         end
         ST_FILL: begin
            // Chain each block to the next one, the last one to null.
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            if (sweep_last) begin
               ram_wr_data = fbpa_pkg::LINK_NULL;
               head_in     = '0;
               state_in    = ST_EMIT;
            end else begin
               ram_wr_data = sweep_next;
               sweep_in    = sweep_next[fbpa_pkg::IDX_W-1:0];
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_used_in   = used_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_used_ff   <= rsp_used_in;
      sweep_ff      <= sweep_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= fbpa_pkg::LINK_NULL;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_index   = rsp_index_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_used_blocks     = rsp_used_ff;

   // The list head is a block index or null, never beyond.
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= fbpa_pkg::LINK_NULL)
      else $error("free list head beyond null");

   // The in-use count saturates at the pool size.
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= fbpa_pkg::LINK_NULL)
      else $error("in-use count beyond pool size");

   // The address unit finishes exactly while the sequencer waits for it.
   a_addr_timing: assert property (@(posedge clock) disable iff (reset)
      addr_done |-> (state_ff == ST_ALLOC_ADDR))
      else $error("address unit result out of step with sequencer");

   // An allocate on a non-empty list never reports an empty pool.
   a_alloc_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC_ADDR) && addr_done |=>
         (state_ff == ST_EMIT) && (res_status_ff == fbpa_pkg::STATUS_OK))
      else $error("allocate result lost");

endmodule

// ===== hw/rtl/fbpa_link_ram.sv =====
module fbpa_link_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fbpa_addr_unit.sv =====
module fbpa_addr_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fbpa_pkg::IDX_W-1:0]   index,
   input  fbpa_pkg::geom_type           geom,
   output logic                         done,
   output logic [fbpa_pkg::ADDR_W-1:0]  address
);

   logic [fbpa_pkg::STRIDE_W-1:0] stride;
   logic [fbpa_pkg::PROD_W-1:0]   prod_ff;
   logic [fbpa_pkg::PROD_W-1:0]   prod_in;
   logic [fbpa_pkg::ADDR_W-1:0]   addr_ff;
   logic [fbpa_pkg::ADDR_W-1:0]   addr_in;
   logic                          v1_ff;
   logic                          v2_ff;

   // Stage one multiplies the index by the stride, stage two adds the base.
   always_comb begin
      stride = fbpa_pkg::STRIDE_W'(geom.block_size)
             + fbpa_pkg::STRIDE_W'(geom.block_alignment);
      prod_in = fbpa_pkg::PROD_W'(index) * fbpa_pkg::PROD_W'(stride);
      addr_in = geom.base_address + fbpa_pkg::ADDR_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      addr_ff <= addr_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
   end

   assign done = v2_ff;
   assign address = addr_ff;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   import fbpa_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES = 7;
   localparam int PHASE_ITEMS = 75;
   localparam int SHOWN_MISMATCHES = 10;

   // One response beat as the pool should report it.
   typedef struct packed {
      status_type          status;
      logic [IDX_W-1:0]    index;
      logic [ADDR_W-1:0]   addr;
      logic [LINK_W-1:0]   used;
   } grant_type;

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_TYPED,
      ROW_CSR
   } row_op_type;

   // A directed step: a request whose response comes from the predictor, a request
   // with its response typed in (value holds the address), or a register write.
   typedef struct packed {
      row_op_type          op;
      kind_type            kind;
      logic [IDX_W-1:0]    idx;
      logic                nb;
      csr_index_type       reg_sel;
      logic [ADDR_W-1:0]   value;
      status_type          status;
      logic [IDX_W-1:0]    g_index;
      logic [LINK_W-1:0]   used;
   } plan_row_type;

   localparam plan_row_type PLAN [33] = '{
      // Empty list after reset, ignored fields at their extremes.
      '{ROW_TYPED, KIND_ALLOC, 10'd1023, 1'b1, CSR_BLOCK_COUNT, 48'd0, STATUS_EMPTY, 10'd0, 11'd0},
      '{ROW_TYPED, KIND_FREE, 10'd1023, 1'b1, CSR_BLOCK_COUNT, 48'd0, STATUS_NULL_FREE, 10'd0,
        11'd0},
      '{ROW_TYPED, KIND_NONE, 10'd1023, 1'b1, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      // A free with nothing in use keeps the count at zero.
      '{ROW_TYPED, KIND_FREE, 10'd1023, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      '{ROW_TYPED, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd65472, STATUS_OK, 10'd1023,
        11'd1},
      '{ROW_TYPED, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_EMPTY, 10'd0, 11'd1},
      '{ROW_TYPED, KIND_FREE_ALL, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      '{ROW_TYPED, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd1},
      '{ROW_TYPED, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd64, STATUS_OK, 10'd1, 11'd2},
      // Double free of the same block, then a pop through the self link.
      '{ROW_PREDICT, KIND_FREE, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      '{ROW_PREDICT, KIND_FREE, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      '{ROW_PREDICT, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      // Largest stride and base, so addresses wrap.
      '{ROW_CSR, KIND_NONE, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd3, STATUS_OK, 10'd0, 11'd0},
      '{ROW_CSR, KIND_NONE, 10'd0, 1'b0, CSR_BLOCK_SIZE, 48'd65535, STATUS_OK, 10'd0, 11'd0},
      '{ROW_CSR, KIND_NONE, 10'd0, 1'b0, CSR_BLOCK_ALIGNMENT, 48'd8191, STATUS_OK, 10'd0, 11'd0},
      '{ROW_CSR, KIND_NONE, 10'd0, 1'b0, CSR_BASE_ADDRESS, 48'hFFFF_FFFF_FFFF, STATUS_OK, 10'd0,
        11'd0},
      '{ROW_TYPED, KIND_FREE_ALL, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      '{ROW_TYPED, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'hFFFF_FFFF_FFFF, STATUS_OK,
        10'd0, 11'd1},
      '{ROW_PREDICT, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      '{ROW_PREDICT, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      '{ROW_TYPED, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_EMPTY, 10'd0, 11'd3},
      // Frees at and past the pool bound.
      '{ROW_TYPED, KIND_FREE, 10'd3, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_RANGE, 10'd0, 11'd3},
      '{ROW_TYPED, KIND_FREE, 10'd1023, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_RANGE, 10'd0,
        11'd3},
      '{ROW_PREDICT, KIND_FREE, 10'd2, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      // A pool of zero blocks stays empty after a rebuild.
      '{ROW_CSR, KIND_NONE, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      '{ROW_TYPED, KIND_FREE_ALL, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      '{ROW_TYPED, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_EMPTY, 10'd0, 11'd0},
      '{ROW_TYPED, KIND_FREE, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_RANGE, 10'd0, 11'd0},
      // A count above the pool size is clipped, then shrunk with the old chain kept.
      '{ROW_CSR, KIND_NONE, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd2047, STATUS_OK, 10'd0, 11'd0},
      '{ROW_PREDICT, KIND_FREE_ALL, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0,
        11'd0},
      '{ROW_CSR, KIND_NONE, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd1, STATUS_OK, 10'd0, 11'd0},
      '{ROW_PREDICT, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0},
      '{ROW_PREDICT, KIND_ALLOC, 10'd0, 1'b0, CSR_BLOCK_COUNT, 48'd0, STATUS_OK, 10'd0, 11'd0}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_kind;
   logic [IDX_W-1:0]     req_block_index;
   logic                 req_no_block;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_status;
   logic [IDX_W-1:0]     rsp_granted_index;
   logic [ADDR_W-1:0]    rsp_granted_address;
   logic [LINK_W-1:0]    rsp_used_blocks;

   // Shadow of the pool: link memory, list head, usage count and registers.
   logic [LINK_W-1:0]    links [POOL_BLOCKS];
   logic [LINK_W-1:0]    list_head;
   logic [LINK_W-1:0]    blocks_in_use;
   logic [COUNT_W-1:0]   cfg_count;
   logic [SIZE_W-1:0]    cfg_size;
   logic [ALIGN_W-1:0]   cfg_align;
   logic [ADDR_W-1:0]    cfg_base;

   grant_type            pending_grants [$];
   logic [IDX_W-1:0]     held_blocks [$];
   int                   fail_count = 0;
   int                   quiet_cycles = 0;
   bit                   steady = 1'b0;
   bit                   hold_request = 1'b0;

   fixed_block_pool_allocator u_dut (.*);

   always #10 clock = ~clock;

   function automatic int usable_blocks();
      return (int'(cfg_count) > POOL_BLOCKS) ? POOL_BLOCKS : int'(cfg_count);
   endfunction

   // Applies one accepted request to the shadow pool and returns the response it owes.
   function automatic void predict_request(input kind_type kind, input logic [IDX_W-1:0] idx,
                                           input logic nb, output grant_type g);
      int n;
      logic [63:0] span;
      n = usable_blocks();
      g = '0;
      case (kind)
         KIND_ALLOC: begin
            if (list_head >= LINK_NULL) begin
               g.status = STATUS_EMPTY;
            end else begin
               g.index = list_head[IDX_W-1:0];
               span = 64'(cfg_size) + 64'(cfg_align);
               g.addr = ADDR_W'(64'(cfg_base) + 64'(list_head) * span);
               list_head = links[g.index];
               if (list_head > LINK_NULL) begin
                  list_head = LINK_NULL;
               end
               if (blocks_in_use < LINK_NULL) begin
                  blocks_in_use = blocks_in_use + LINK_W'(1);
               end
            end
         end
         KIND_FREE: begin
            if (nb) begin
               g.status = STATUS_NULL_FREE;
            end else if (int'(idx) >= n) begin
               g.status = STATUS_RANGE;
            end else begin
               links[idx] = list_head;
               list_head = LINK_W'(idx);
               if (blocks_in_use != '0) begin
                  blocks_in_use = blocks_in_use - LINK_W'(1);
               end
            end
         end
         KIND_FREE_ALL: begin
            blocks_in_use = '0;
            for (int i = 0; i < n; i++) begin
               links[i] = (i + 1 < n) ? LINK_W'(i + 1) : LINK_NULL;
            end
            list_head = (n > 0) ? '0 : LINK_NULL;
         end
         default: begin
         end
      endcase
      g.used = blocks_in_use;
   endfunction

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= SHOWN_MISMATCHES) begin
         $display("%s", what);
      end
   endtask

   // Offers one request beat, holds it until taken, then records the response it owes.
   task automatic send_item(input kind_type kind, input logic [IDX_W-1:0] idx, input logic nb,
                            input bit typed = 1'b0, input grant_type typed_grant = '0);
      grant_type predicted;
      csr_write <= 1'b0;
      if (!steady && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_block_index <= idx;
      req_no_block <= nb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(kind, idx, nb, predicted);
      pending_grants.push_back(typed ? typed_grant : predicted);
      if (kind == KIND_ALLOC && predicted.status == STATUS_OK) begin
         held_blocks.push_back(predicted.index);
      end else if (kind == KIND_FREE_ALL) begin
         held_blocks.delete();
      end
   endtask

   // Register writes wait until every owed response has been seen.
   task automatic write_reg(input csr_index_type sel, input logic [ADDR_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      case (sel)
         CSR_BLOCK_COUNT:     cfg_count = value[COUNT_W-1:0];
         CSR_BLOCK_SIZE:      cfg_size = value[SIZE_W-1:0];
         CSR_BLOCK_ALIGNMENT: cfg_align = value[ALIGN_W-1:0];
         default:             cfg_base = value;
      endcase
   endtask

   // Mostly allocations and returns of granted blocks, with rebuilds, none requests, stray and null frees.
   task automatic send_random_item();
      int roll;
      int pick;
      int rebuild_pct;
      logic [IDX_W-1:0] idx;
      logic nb;
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      idx = IDX_W'($urandom);
      nb = 1'($urandom_range(1));
      rebuild_pct = (usable_blocks() <= 64) ? 3 : 1;
      if (roll < rebuild_pct) begin
         send_item(KIND_FREE_ALL, idx, nb);
      end else if (roll < rebuild_pct + 4) begin
         send_item(KIND_NONE, idx, nb);
      end else if (roll < rebuild_pct + 36) begin
         if (pick < 70 && held_blocks.size() != 0) begin
            pick = $urandom_range(held_blocks.size() - 1);
            idx = held_blocks[pick];
            held_blocks.delete(pick);
            nb = 1'b0;
         end else if (pick < 80) begin
            nb = 1'b1;
         end else begin
            nb = 1'b0;
            if (pick < 90) begin
               idx = IDX_W'($urandom_range(usable_blocks()));
            end
         end
         send_item(KIND_FREE, idx, nb);
      end else begin
         send_item(KIND_ALLOC, idx, nb);
      end
   endtask

   // Response side: compare each beat with the oldest owed response; track idle cycles.
   always @(posedge clock) begin : check_results
      grant_type want;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            note_failure($sformatf("unexpected beat: status %0d index %0d address %h used %0d",
                                   rsp_status, rsp_granted_index, rsp_granted_address,
                                   rsp_used_blocks));
         end else begin
            want = pending_grants.pop_front();
            if (rsp_status !== want.status || rsp_granted_index !== want.index ||
                rsp_granted_address !== want.addr || rsp_used_blocks !== want.used) begin
               note_failure($sformatf({"mismatch (expected/actual): status %0d/%0d ",
                                       "index %0d/%0d address %h/%h used %0d/%0d"},
                                      want.status, rsp_status, want.index, rsp_granted_index,
                                      want.addr, rsp_granted_address, want.used,
                                      rsp_used_blocks));
            end
         end
      end
   end

   // Receiver: random short stalls, one long hold-off, none while steady.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 16);
         end
      end
   end

   // Ends the run if no beat moves on either side for too long.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [ADDR_W-1:0] count_v;
      logic [ADDR_W-1:0] size_v;
      logic [ADDR_W-1:0] align_v;
      logic [ADDR_W-1:0] base_v;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_BLOCK_COUNT;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_kind = KIND_ALLOC;
      req_block_index = '0;
      req_no_block = 1'b0;
      cfg_count = COUNT_W'(1024);
      cfg_size = SIZE_W'(64);
      cfg_align = '0;
      cfg_base = '0;
      list_head = LINK_NULL;
      blocks_in_use = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed steps.
      for (int i = 0; i < $size(PLAN); i++) begin
         case (PLAN[i].op)
            ROW_CSR: begin
               write_reg(PLAN[i].reg_sel, PLAN[i].value);
            end
            ROW_TYPED: begin
               send_item(PLAN[i].kind, PLAN[i].idx, PLAN[i].nb, 1'b1,
                         grant_type'{PLAN[i].status, PLAN[i].g_index, PLAN[i].value,
                                     PLAN[i].used});
            end
            default: begin
               send_item(PLAN[i].kind, PLAN[i].idx, PLAN[i].nb);
            end
         endcase
      end

      // Random phases, each with its own pool geometry.
      for (int p = 0; p < PHASES; p++) begin
         size_v = ADDR_W'($urandom_range(1, 65535));
         align_v = ADDR_W'($urandom_range(0, 4096));
         base_v = ADDR_W'({$urandom, $urandom});
         count_v = ADDR_W'($urandom_range(2, 64));
         case (p)
            0: count_v = ADDR_W'(16);
            1: begin
               count_v = ADDR_W'(1);
               size_v = ADDR_W'(1);
               align_v = '0;
               base_v = '0;
            end
            2: begin
               count_v = ADDR_W'(1024);
               size_v = ADDR_W'(65535);
               align_v = ADDR_W'(4096);
               base_v = '1;
            end
            4: count_v = ADDR_W'($urandom_range(2, 40));
            5: begin
               count_v = ADDR_W'(2047);
               align_v = '0;
            end
            6: begin
               count_v = ADDR_W'($urandom_range(1, 32));
               align_v = ADDR_W'(8191);
            end
            default: begin
            end
         endcase
         steady = (p == 4);
         write_reg(CSR_BLOCK_COUNT, count_v);
         write_reg(CSR_BLOCK_SIZE, size_v);
         write_reg(CSR_BLOCK_ALIGNMENT, align_v);
         write_reg(CSR_BASE_ADDRESS, base_v);
         // The steady phase keeps the chain left over from before the count change.
         if (p != 4) begin
            send_item(KIND_FREE_ALL, IDX_W'($urandom), 1'($urandom_range(1)));
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 3 && k == 10) begin
               hold_request = 1'b1;
            end
            send_random_item();
         end
      end
      steady = 1'b0;

      // Drain, then watch for any stray beat.
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0 && pending_grants.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
